@@ design/hitp_pkg.sv @@
// Shared types, constants and decode helpers for the hex identifier text parser.
`timescale 1ns / 1ps
package hitp_pkg;

    // Hex digits in each component of the identifier text
    localparam int COMPONENT_DIGITS = 16;
    // Character count of a well-formed text: digits, colon, digits
    localparam int TEXT_CHARS       = 2 * COMPONENT_DIGITS + 1;
    localparam int POS_W            = 6;
    localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] SEP_POS   = POS_W'(COMPONENT_DIGITS);
    localparam logic [POS_W-1:0] TEXT_LEN  = POS_W'(TEXT_CHARS);
    localparam int ID_W             = 64;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEN  = 2'd1,
        ST_BAD_HEX  = 2'd2,
        ST_ZERO_ID  = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_beat;

    typedef struct packed {
        t_status         status;
        logic [ID_W-1:0] namespace_id;
        logic [ID_W-1:0] sequence_id;
    } t_out_beat;

    // Classification of one character
    typedef struct packed {
        logic       is_hex;
        logic       is_colon;
        logic [3:0] nibble;
    } t_char_class;

endpackage

@@ design/hex_id_text_parser.sv @@
// Top level: input register, parse core and result register with handshakes.
`timescale 1ns / 1ps
// Hex identifier text parser. Feed one character per input beat, with
// last_char set on the final one; a well-formed text is 16 hex digits (either
// case), a colon and 16 more. Each text yields one result beat carrying a
// status and the two 64-bit values, which read zero unless the status is OK.
// The block takes one character per cycle unless stalled: a character is held
// in the input register, is folded into the parse state, and the last one
// loads the result register from there. Input stalls only while a result is
// waiting and a finished text needs the result register.
module hex_id_text_parser
    import hitp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid;
    t_out_beat r_out;
    t_out_beat w_result;
    logic      w_out_free;
    logic      w_advance;

    assign w_out_free = ~r_out_valid | i_out_ready;
    // Non-final characters never need the result register
    assign w_advance  = r_in_valid & (~r_in.last_char | w_out_free);
    assign o_in_ready = ~r_in_valid | w_advance;

    hitp_parse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_beat   (r_in),
        .o_result (w_result)
    );

    // Hold the accepted beat until the core takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Load the result on the final character, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in.last_char) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in.last_char) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A failed text never carries values
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |->
            (o_out_data.namespace_id == '0 && o_out_data.sequence_id == '0))
        else $error("nonzero value on error status");

    // An OK result has both components nonzero
    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_OK) |->
            (o_out_data.namespace_id != '0 && o_out_data.sequence_id != '0))
        else $error("zero value with OK status");

    // A new result follows a final character taken by the core
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_advance && r_in.last_char))
        else $error("result without final character");

    // A held result is never overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(w_advance && r_in.last_char))
        else $error("result register overrun");

endmodule

@@ design/hitp_char_decode.sv @@
// Character classifier: hex digit value, hex validity and separator match.
`timescale 1ns / 1ps
module hitp_char_decode
    import hitp_pkg::*;
(
    input  logic [7:0]  i_char_code,
    output t_char_class o_class
);

    always_comb begin
        o_class.is_colon = (i_char_code == CHAR_COLON);
        o_class.is_hex   = 1'b0;
        o_class.nibble   = 4'd0;
        // Map 0-9, a-f and A-F; anything else decodes as zero
        if (i_char_code >= 8'h30 && i_char_code <= 8'h39) begin
            o_class.is_hex = 1'b1;
            o_class.nibble = 4'(i_char_code - 8'h30);
        end else if (i_char_code >= 8'h61 && i_char_code <= 8'h66) begin
            o_class.is_hex = 1'b1;
            o_class.nibble = 4'(i_char_code - 8'h57);
        end else if (i_char_code >= 8'h41 && i_char_code <= 8'h46) begin
            o_class.is_hex = 1'b1;
            o_class.nibble = 4'(i_char_code - 8'h37);
        end
    end

endmodule

@@ design/hitp_parse_core.sv @@
// Parse state: position count, two accumulators, error flags and result build.
`timescale 1ns / 1ps
module hitp_parse_core
    import hitp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_in_beat    i_beat,
    output t_out_beat   o_result
);

    t_char_class      w_class;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [ID_W-1:0]  r_first, n_first;
    logic [ID_W-1:0]  r_second, n_second;
    logic             r_sep_bad, n_sep_bad;
    logic             r_digit_bad, n_digit_bad;
    t_status          w_status;

    hitp_char_decode u_decode (
        .i_char_code (i_beat.char_code),
        .o_class     (w_class)
    );

    // Route the character by position and advance the count
    always_comb begin
        n_first     = r_first;
        n_second    = r_second;
        n_sep_bad   = r_sep_bad;
        n_digit_bad = r_digit_bad;
        if (r_pos < SEP_POS) begin
            n_first     = {r_first[ID_W-5:0], w_class.nibble};
            n_digit_bad = r_digit_bad | ~w_class.is_hex;
        end else if (r_pos == SEP_POS) begin
            n_sep_bad   = r_sep_bad | ~w_class.is_colon;
        end else if (r_pos < TEXT_LEN) begin
            n_second    = {r_second[ID_W-5:0], w_class.nibble};
            n_digit_bad = r_digit_bad | ~w_class.is_hex;
        end
        n_pos = (r_pos < POS_MAX) ? r_pos + 1'b1 : POS_MAX;
    end

    // Build status in priority order: length/separator, digit, zero value
    always_comb begin
        if (n_pos != TEXT_LEN || n_sep_bad) begin
            w_status = ST_BAD_LEN;
        end else if (n_digit_bad) begin
            w_status = ST_BAD_HEX;
        end else if (n_first == '0 || n_second == '0) begin
            w_status = ST_ZERO_ID;
        end else begin
            w_status = ST_OK;
        end
        o_result.status       = w_status;
        o_result.namespace_id = (w_status == ST_OK) ? n_first  : '0;
        o_result.sequence_id  = (w_status == ST_OK) ? n_second : '0;
    end

    // Update on each beat; clear after the last character of a text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_first     <= '0;
            r_second    <= '0;
            r_sep_bad   <= 1'b0;
            r_digit_bad <= 1'b0;
        end else if (i_step) begin
            if (i_beat.last_char) begin
                r_pos       <= '0;
                r_first     <= '0;
                r_second    <= '0;
                r_sep_bad   <= 1'b0;
                r_digit_bad <= 1'b0;
            end else begin
                r_pos       <= n_pos;
                r_first     <= n_first;
                r_second    <= n_second;
                r_sep_bad   <= n_sep_bad;
                r_digit_bad <= n_digit_bad;
            end
        end
    end

endmodule

@@ tb/hex_id_text_parser_tb.sv @@
// Self-checking testbench for the hex identifier text parser, random and directed texts.
`timescale 1ns / 1ps
module hex_id_text_parser_tb;
    import hitp_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam logic [7:0] CH_0  = "0";
    localparam logic [7:0] CH_9  = "9";
    localparam logic [7:0] CH_LA = "a";
    localparam logic [7:0] CH_LF = "f";
    localparam logic [7:0] CH_UA = "A";
    localparam logic [7:0] CH_UF = "F";

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_ready = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_beat o_out_data;

    // Stimulus and expected results
    t_in_beat   char_queue[$];
    t_out_beat  pending_results[$];
    logic [7:0] text_buf[$];

    // Parse state of the predictor
    logic [POS_W-1:0] scan_pos = '0;
    logic [ID_W-1:0]  ns_acc   = '0;
    logic [ID_W-1:0]  seq_acc  = '0;
    logic             sep_err  = 1'b0;
    logic             hex_err  = 1'b0;

    // Run control and bookkeeping
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic in_took        = 1'b0;
    logic hold_go        = 1'b0;
    logic hold_done      = 1'b0;
    int   hold_left      = 0;
    int   cycle_count    = 0;
    int   mismatch_count = 0;
    int   chars_queued   = 0;
    int   texts_queued   = 0;
    int   results_seen   = 0;
    int   input_stalls   = 0;
    int   status_seen[4] = '{0, 0, 0, 0};

    hex_id_text_parser DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Fold one accepted character into the parse state; emit the result on the last one
    task automatic fold_char(input t_in_beat beat);
        logic [7:0]       c;
        logic [3:0]       nib;
        logic             is_digit;
        logic [POS_W-1:0] count;
        t_out_beat        res;
        c        = beat.char_code;
        is_digit = 1'b1;
        nib      = '0;
        if (c >= CH_0 && c <= CH_9)        nib = 4'(c - CH_0);
        else if (c >= CH_LA && c <= CH_LF) nib = 4'(c - CH_LA + 8'd10);
        else if (c >= CH_UA && c <= CH_UF) nib = 4'(c - CH_UA + 8'd10);
        else                               is_digit = 1'b0;

        if (scan_pos < SEP_POS) begin
            hex_err = hex_err | ~is_digit;
            ns_acc  = {ns_acc[ID_W-5:0], nib};
        end else if (scan_pos == SEP_POS) begin
            sep_err = sep_err | (c != CHAR_COLON);
        end else if (scan_pos < TEXT_LEN) begin
            hex_err = hex_err | ~is_digit;
            seq_acc = {seq_acc[ID_W-5:0], nib};
        end
        count    = (scan_pos != POS_MAX) ? scan_pos + 1'b1 : POS_MAX;
        scan_pos = count;

        if (beat.last_char) begin
            res.namespace_id = ns_acc;
            res.sequence_id  = seq_acc;
            if (count != TEXT_LEN || sep_err)       res.status = ST_BAD_LEN;
            else if (hex_err)                       res.status = ST_BAD_HEX;
            else if (ns_acc == '0 || seq_acc == '0) res.status = ST_ZERO_ID;
            else                                    res.status = ST_OK;
            if (res.status != ST_OK) begin
                res.namespace_id = '0;
                res.sequence_id  = '0;
            end
            pending_results.push_back(res);
            scan_pos = '0;
            ns_acc   = '0;
            seq_acc  = '0;
            sep_err  = 1'b0;
            hex_err  = 1'b0;
        end
    endtask

    // Random hex digit in either case
    function automatic logic [7:0] rand_hex_char();
        logic [7:0] v;
        v = 8'($urandom_range(15));
        if (v < 8'd10)              return CH_0 + v;
        else if ($urandom_range(1)) return CH_LA + v - 8'd10;
        else                        return CH_UA + v - 8'd10;
    endfunction

    // Move the text buffer into the character queue, marking its last beat
    task automatic queue_text();
        t_in_beat beat;
        foreach (text_buf[i]) begin
            beat.char_code = text_buf[i];
            beat.last_char = (i == text_buf.size() - 1);
            char_queue.push_back(beat);
        end
        chars_queued += text_buf.size();
        texts_queued++;
        text_buf.delete();
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    // Mostly well-formed texts with random digits, the rest damaged or plain noise
    task automatic queue_random_texts(input int n_chars);
        int target;
        int kind;
        int zero_part;
        int len;
        target = chars_queued + n_chars;
        while (chars_queued < target) begin
            kind      = $urandom_range(99);
            zero_part = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0;
            for (int i = 0; i < TEXT_CHARS; i++) begin
                if (i == COMPONENT_DIGITS)
                    text_buf.push_back(CHAR_COLON);
                else if ((zero_part == 1 && i < COMPONENT_DIGITS) ||
                         (zero_part == 2 && i > COMPONENT_DIGITS))
                    text_buf.push_back(CH_0);
                else
                    text_buf.push_back(rand_hex_char());
            end
            if (kind >= 60 && kind < 70) begin
                text_buf[$urandom_range(TEXT_CHARS - 1)] = 8'($urandom_range(255));
            end else if (kind >= 70 && kind < 80) begin
                if ($urandom_range(1)) begin
                    len = $urandom_range(1, TEXT_CHARS - 1);
                    while (text_buf.size() > len) text_buf.pop_back();
                end else begin
                    repeat ($urandom_range(1, 35))
                        text_buf.push_back($urandom_range(1) ? rand_hex_char()
                                                             : 8'($urandom_range(255)));
                end
            end else if (kind >= 80 && kind < 90) begin
                text_buf[COMPONENT_DIGITS] = 8'($urandom_range(255));
            end else if (kind >= 90) begin
                text_buf.delete();
                repeat ($urandom_range(1, 40)) text_buf.push_back(8'($urandom_range(255)));
            end
            queue_text();
        end
    endtask

    // Block until every queued character has been accepted
    task automatic wait_sent();
        while (char_queue.size() != 0 || in_valid) @(posedge i_clk);
    endtask

    // Sender: advance to the next beat after acceptance, idle at random
    always @(negedge i_clk) begin
        if (!in_valid || in_took) begin
            if (char_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_beat  <= char_queue.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: one long hold-off on request, otherwise stall at random
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on input beats, check output beats, watch the cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        in_took     <= in_valid && o_in_ready;
        if (in_valid && !o_in_ready && i_rst_n) input_stalls <= input_stalls + 1;
        if (in_valid && o_in_ready) fold_char(in_beat);
        if (o_out_valid && out_ready) begin
            results_seen <= results_seen + 1;
            status_seen[o_out_data.status] <= status_seen[o_out_data.status] + 1;
            if (pending_results.size() == 0) begin
                report_mismatch("result with none pending, status", 64'(o_out_data.status), '0);
            end else begin
                if (o_out_data.status != pending_results[0].status)
                    report_mismatch("status", 64'(o_out_data.status),
                                    64'(pending_results[0].status));
                if (o_out_data.namespace_id != pending_results[0].namespace_id)
                    report_mismatch("namespace_id", o_out_data.namespace_id,
                                    pending_results[0].namespace_id);
                if (o_out_data.sequence_id != pending_results[0].sequence_id)
                    report_mismatch("sequence_id", o_out_data.sequence_id,
                                    pending_results[0].sequence_id);
                void'(pending_results.pop_front());
            end
        end
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed texts: extremes, both cases, every status and each error order
        put_str("FFFFFFFFFFFFFFFF:FFFFFFFFFFFFFFFF"); queue_text();
        put_str("0123456789abcdef:ABCDEF0123456789"); queue_text();
        put_str("0000000000000001:0000000000000001"); queue_text();
        put_str("0000000000000000:0000000000000000"); queue_text();
        put_str("0000000000000000:0000000000000001"); queue_text();
        put_str("fedcba9876543210:0000000000000000"); queue_text();
        put_str("@1234567890abcG`:g1234567890ABCD/"); queue_text();
        put_str("11111111:1111111:2222222222222222"); queue_text();
        put_str("1111111111111111;2222222222222222"); queue_text();
        put_str("x111111111111111-22222222222222");
        text_buf.push_back(8'hFF);
        text_buf.push_back(8'h00);
        queue_text();
        put_str("A"); queue_text();
        put_str("1111111111111111:222222222222222"); queue_text();
        put_str("1111111111111111:22222222222222223"); queue_text();
        put_str("1111111111111111:2222222222222222");
        put_str("ZZZZZZZZZZ::::::::::0123456789abcdefABCDEF"); queue_text();
        queue_random_texts(100);
        wait_sent();

        // Random texts under each idling mix
        send_idle_pct = 71; recv_stall_pct = 0;
        queue_random_texts(250);
        wait_sent();
        send_idle_pct = 0; recv_stall_pct = 71;
        queue_random_texts(250);
        wait_sent();
        send_idle_pct = 30; recv_stall_pct = 30;
        queue_random_texts(250);
        wait_sent();

        // Hold off the receiver while short texts keep arriving, so the input backs up
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_go = 1'b1;
        for (int t = 0; t < 60; t++) begin
            repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(255)));
            queue_text();
        end
        while (!hold_done || hold_left != 0) @(posedge i_clk);
        wait_sent();

        send_idle_pct = 20; recv_stall_pct = 20;
        queue_random_texts(150);
        wait_sent();

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered, count", 64'(pending_results.size()), '0);

        $display("Sent %0d characters in %0d texts; input held back for %0d cycles.",
                 chars_queued, texts_queued, input_stalls);
        $display("Checked %0d results: ok %0d, length/separator %0d, hex %0d, zero %0d.",
                 results_seen, status_seen[ST_OK], status_seen[ST_BAD_LEN],
                 status_seen[ST_BAD_HEX], status_seen[ST_ZERO_ID]);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
